// ===== rtl/scv_pkg.sv =====
// Shared types and constants for the strided 1D convolution engine.
package scv_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam int MAX_STRIDE = 8;
    localparam int SAMPLE_W   = 16;
    localparam int PROD_W     = 32;
    localparam int ACC_W      = 48;

    localparam logic CMD_WEIGHT = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TAPS   = 2'd0,
        CFG_STRIDE = 2'd1,
        CFG_IN_CH  = 2'd2,
        CFG_OUT_CH = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_COPY = 4'b0010,
        S_MAC  = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    typedef struct packed {
        logic                       cmd;
        logic [2:0]                 tap_index;
        logic [3:0]                 in_channel_index;
        logic [3:0]                 out_channel_index;
        logic signed [SAMPLE_W-1:0] data_value;
        logic                       end_of_sequence;
    } in_item_t;

    typedef struct packed {
        logic [15:0]             out_time;
        logic [3:0]              out_channel;
        logic signed [ACC_W-1:0] conv_sum;
        logic                    last_of_frame;
    } out_item_t;

    // MAC pipeline control, travels alongside the operands
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } mac_ctl_t;

endpackage

// ===== rtl/scv_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
module scv_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 128,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/scv_mac.sv =====
// Two-stage multiply-accumulate: product register, then accumulator.
module scv_mac (
    input  logic                               clk,
    input  logic                               rst_n,
    input  scv_pkg::mac_ctl_t                  ctl,
    input  logic signed [scv_pkg::SAMPLE_W-1:0] sample,
    input  logic signed [scv_pkg::SAMPLE_W-1:0] weight,
    output logic signed [scv_pkg::ACC_W-1:0]   acc,
    output logic                               done
);
    import scv_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    mac_ctl_t                 ctl_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     done_reg;
    logic signed [ACC_W-1:0]  prod_ext;

    assign prod_ext = ACC_W'(prod_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            ctl_reg  <= ctl;
            done_reg <= ctl_reg.valid & ctl_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= sample * weight;
        if (ctl_reg.valid)
        begin
            acc_reg <= ctl_reg.first ? prod_ext : acc_reg + prod_ext;
        end
    end

    assign acc  = acc_reg;
    assign done = done_reg;

endmodule

// ===== rtl/strided_conv1d_engine.sv =====
// Top level: strided multi-channel 1D convolution over two local memories.
//
// Channels: in_valid/in_ready carry weight writes (cmd 0) and samples (cmd 1),
// frame-major, channel 0 first. out_valid/out_ready return one transaction per
// output channel of a completed, stride-aligned window; last_of_frame marks
// the final channel. cfg_valid/cfg_ready writes the four setup registers and
// is always ready; write it only while the block is idle.
// Flow: a weight write leaves the block idle. A sample that continues a frame
// is written straight into the history. A sample that opens a frame starts
// a sweep that copies the previous history row into the newly opened row. A
// frame that produces output then runs the single shared MAC: per output
// channel taps * in_channels products, one output channel after the other.
// The frame history is a circular buffer of MAX_TAPS rows; weights sit in a
// MAX_TAPS*MAX_IN_CH*MAX_OUT_CH word RAM. Neither memory is cleared.
// Reset clears the sequencer, counters and setup registers (taps 3, stride
// 1, 16 channels in and out). A stalled receiver holds the result register;
// the MAC waits for it, and a new input is taken while the last result of a
// frame is still waiting.
module strided_conv1d_engine #(
    parameter int MAX_TAPS   = 8,
    parameter int MAX_IN_CH  = 16,
    parameter int MAX_OUT_CH = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  scv_pkg::in_item_t                in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output scv_pkg::out_item_t               out_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [scv_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [scv_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import scv_pkg::*;

    localparam int ROW_W   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CI_W    = (MAX_IN_CH > 1) ? $clog2(MAX_IN_CH) : 1;
    localparam int CO_W    = (MAX_OUT_CH > 1) ? $clog2(MAX_OUT_CH) : 1;
    localparam int TAPC_W  = $clog2(MAX_TAPS + 1);
    localparam int INC_W   = $clog2(MAX_IN_CH + 1);
    localparam int OUTC_W  = $clog2(MAX_OUT_CH + 1);
    localparam int HDEPTH  = MAX_TAPS * MAX_IN_CH;
    localparam int WDEPTH  = MAX_TAPS * MAX_IN_CH * MAX_OUT_CH;
    localparam int HADDR_W = (HDEPTH > 1) ? $clog2(HDEPTH) : 1;
    localparam int WADDR_W = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;

    // setup registers, raw as written
    logic [3:0] taps_raw_reg;
    logic [3:0] stride_raw_reg;
    logic [4:0] nin_raw_reg;
    logic [4:0] nout_raw_reg;

    logic [TAPC_W-1:0] taps_eff;
    logic [3:0]        stride_eff;
    logic [INC_W-1:0]  nin_eff;
    logic [OUTC_W-1:0] nout_eff;

    // stream state
    state_t            state_reg;
    logic [INC_W-1:0]  chan_pos_reg;
    logic [TAPC_W-1:0] frames_seen_reg;
    logic [2:0]        phase_reg;
    logic [15:0]       ofc_reg;
    logic [ROW_W-1:0]  head_reg;
    logic [ROW_W-1:0]  prev_row_reg;
    logic [15:0]       out_time_reg;
    logic              emit_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;

    // copy sweep
    logic [INC_W-1:0] copy_cnt_reg;
    logic             copy_wv_reg;
    logic [CI_W-1:0]  copy_wci_reg;

    // MAC issue
    logic             iss_v_reg;
    logic [ROW_W-1:0] kt_reg;
    logic [CI_W-1:0]  ci_reg;
    logic [ROW_W-1:0] row_reg;
    logic [CO_W-1:0]  co_reg;
    mac_ctl_t         rd_ctl_reg;

    logic      out_valid_reg;
    out_item_t out_data_reg;

    // accept decode
    logic              in_acc;
    logic              acc_weight;
    logic              acc_sample;
    logic [INC_W-1:0]  cp;
    logic [INC_W-1:0]  cp_inc;
    logic              frame_done;
    logic [TAPC_W:0]   fs_sum;
    logic [TAPC_W-1:0] fs_next;
    logic              window_full;
    logic              emit_now;
    logic [3:0]        ph_sum;
    logic [2:0]        ph_next;
    logic [ROW_W-1:0]  head_inc;
    logic              w_in_range;

    logic              copy_done;
    logic              out_free;
    logic              co_last;
    logic              iss_last;
    logic              start_mac;
    logic [ROW_W-1:0]  row_start;

    logic                hist_we;
    logic [HADDR_W-1:0]  hist_waddr;
    logic [SAMPLE_W-1:0] hist_wdata;
    logic [HADDR_W-1:0]  hist_raddr;
    logic [SAMPLE_W-1:0] hist_rdata;
    logic                w_we;
    logic [WADDR_W-1:0]  w_waddr;
    logic [WADDR_W-1:0]  w_raddr;
    logic [SAMPLE_W-1:0] w_rdata;

    logic signed [ACC_W-1:0] mac_acc;
    logic                    mac_done;
    mac_ctl_t                iss_ctl;

    function automatic logic [HADDR_W-1:0] hist_addr(input logic [ROW_W-1:0] row,
                                                     input logic [CI_W-1:0] ci);
        int a;
        a = int'(row) * MAX_IN_CH + int'(ci);
        return a[HADDR_W-1:0];
    endfunction

    function automatic logic [WADDR_W-1:0] wt_addr(input int kt, input int ci, input int co);
        int a;
        a = (kt * MAX_IN_CH + ci) * MAX_OUT_CH + co;
        return a[WADDR_W-1:0];
    endfunction

    // effective setup values, zero counts as one, clamp at the maximum
    always_comb
    begin
        if (taps_raw_reg == '0)
            taps_eff = TAPC_W'(1);
        else if (int'(taps_raw_reg) > MAX_TAPS)
            taps_eff = TAPC_W'(MAX_TAPS);
        else
            taps_eff = TAPC_W'(taps_raw_reg);

        if (stride_raw_reg == '0)
            stride_eff = 4'd1;
        else if (int'(stride_raw_reg) > MAX_STRIDE)
            stride_eff = 4'(MAX_STRIDE);
        else
            stride_eff = stride_raw_reg;

        if (nin_raw_reg == '0)
            nin_eff = INC_W'(1);
        else if (int'(nin_raw_reg) > MAX_IN_CH)
            nin_eff = INC_W'(MAX_IN_CH);
        else
            nin_eff = INC_W'(nin_raw_reg);

        if (nout_raw_reg == '0)
            nout_eff = OUTC_W'(1);
        else if (int'(nout_raw_reg) > MAX_OUT_CH)
            nout_eff = OUTC_W'(MAX_OUT_CH);
        else
            nout_eff = OUTC_W'(nout_raw_reg);
    end

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_acc    = in_valid & in_ready;
    assign acc_weight = in_acc & (in_data.cmd == CMD_WEIGHT);
    assign acc_sample = in_acc & (in_data.cmd == CMD_SAMPLE);

    // frame bookkeeping for one sample
    always_comb
    begin
        cp          = (chan_pos_reg >= nin_eff) ? '0 : chan_pos_reg;
        cp_inc      = cp + INC_W'(1);
        frame_done  = (cp_inc >= nin_eff);
        fs_sum      = {1'b0, frames_seen_reg} + (TAPC_W + 1)'(1);
        if (!frame_done)
            fs_next = frames_seen_reg;
        else if (fs_sum > {1'b0, taps_eff})
            fs_next = taps_eff;
        else
            fs_next = fs_sum[TAPC_W-1:0];
        window_full = frame_done & (fs_next >= taps_eff);
        emit_now    = window_full & (phase_reg == 3'd0);
        ph_sum      = {1'b0, phase_reg} + 4'd1;
        if (!window_full)
            ph_next = phase_reg;
        else if (ph_sum >= stride_eff)
            ph_next = 3'd0;
        else
            ph_next = ph_sum[2:0];
        head_inc    = (int'(head_reg) == MAX_TAPS - 1) ? '0 : head_reg + ROW_W'(1);
        w_in_range  = (int'(in_data.tap_index) < MAX_TAPS) &&
                      (int'(in_data.in_channel_index) < MAX_IN_CH) &&
                      (int'(in_data.out_channel_index) < MAX_OUT_CH);
    end

    // oldest window row: head - (taps - 1), modulo the row count
    always_comb
    begin
        int r;
        r = int'(head_reg) - (int'(taps_eff) - 1);
        if (r < 0)
            r = r + MAX_TAPS;
        row_start = r[ROW_W-1:0];
    end

    assign copy_done = (state_reg == S_COPY) && (int'(copy_cnt_reg) == MAX_IN_CH) && copy_wv_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign co_last   = (int'(co_reg) == int'(nout_eff) - 1);
    assign iss_last  = (int'(kt_reg) == int'(taps_eff) - 1) &&
                       (int'(ci_reg) == int'(nin_eff) - 1);
    assign start_mac = (acc_sample && (cp != '0) && emit_now) ||
                       (copy_done && emit_reg) ||
                       ((state_reg == S_OUT) && out_free && !co_last);

    // setup register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taps_raw_reg   <= 4'd3;
            stride_raw_reg <= 4'd1;
            nin_raw_reg    <= 5'd16;
            nout_raw_reg   <= 5'd16;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_TAPS:   taps_raw_reg   <= cfg_data[3:0];
                CFG_STRIDE: stride_raw_reg <= cfg_data[3:0];
                CFG_IN_CH:  nin_raw_reg    <= cfg_data;
                CFG_OUT_CH: nout_raw_reg   <= cfg_data;
                default:    ;
            endcase
        end
    end

    // sequencer and stream counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            chan_pos_reg    <= '0;
            frames_seen_reg <= '0;
            phase_reg       <= '0;
            ofc_reg         <= '0;
            head_reg        <= '0;
            emit_reg        <= 1'b0;
            copy_cnt_reg    <= '0;
            copy_wv_reg     <= 1'b0;
            iss_v_reg       <= 1'b0;
            rd_ctl_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            rd_ctl_reg <= iss_ctl;
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (acc_sample)
                    begin
                        emit_reg <= emit_now;
                        if (in_data.end_of_sequence)
                        begin
                            chan_pos_reg    <= '0;
                            frames_seen_reg <= '0;
                            phase_reg       <= '0;
                            ofc_reg         <= '0;
                        end
                        else
                        begin
                            chan_pos_reg    <= frame_done ? '0 : cp_inc;
                            frames_seen_reg <= fs_next;
                            phase_reg       <= ph_next;
                            ofc_reg         <= emit_now ? ofc_reg + 16'd1 : ofc_reg;
                        end
                        if (cp == '0)
                        begin
                            // new frame opens a fresh history row
                            head_reg     <= head_inc;
                            copy_cnt_reg <= '0;
                            copy_wv_reg  <= 1'b0;
                            state_reg    <= S_COPY;
                        end
                        else if (emit_now)
                        begin
                            state_reg <= S_MAC;
                        end
                    end
                end
                S_COPY:
                begin
                    if (int'(copy_cnt_reg) < MAX_IN_CH)
                        copy_cnt_reg <= copy_cnt_reg + INC_W'(1);
                    copy_wv_reg <= (int'(copy_cnt_reg) < MAX_IN_CH);
                    if (copy_done)
                        state_reg <= emit_reg ? S_MAC : S_IDLE;
                end
                S_MAC:
                begin
                    if (mac_done)
                        state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= co_last ? S_IDLE : S_MAC;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase

            if (start_mac)
                iss_v_reg <= 1'b1;
            else if (iss_v_reg && iss_last)
                iss_v_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (acc_sample)
        begin
            sample_reg   <= in_data.data_value;
            prev_row_reg <= head_reg;
            out_time_reg <= ofc_reg;
        end
        copy_wci_reg <= copy_cnt_reg[CI_W-1:0];

        if (start_mac)
        begin
            kt_reg  <= '0;
            ci_reg  <= '0;
            row_reg <= row_start;
            if (state_reg == S_OUT)
                co_reg <= co_reg + CO_W'(1);
            else
                co_reg <= '0;
        end
        else if (iss_v_reg)
        begin
            if (int'(ci_reg) == int'(nin_eff) - 1)
            begin
                ci_reg  <= '0;
                kt_reg  <= kt_reg + ROW_W'(1);
                row_reg <= (int'(row_reg) == MAX_TAPS - 1) ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                ci_reg <= ci_reg + CI_W'(1);
            end
        end

        if ((state_reg == S_OUT) && out_free)
        begin
            out_data_reg.out_time      <= out_time_reg;
            out_data_reg.out_channel   <= 4'(co_reg);
            out_data_reg.conv_sum      <= mac_acc;
            out_data_reg.last_of_frame <= co_last;
        end
    end

    assign iss_ctl.valid = iss_v_reg;
    assign iss_ctl.first = (kt_reg == '0) && (ci_reg == '0);
    assign iss_ctl.last  = iss_last;

    // history RAM ports: direct sample write, or copy sweep of the prior row
    always_comb
    begin
        if (state_reg == S_COPY)
        begin
            hist_we    = copy_wv_reg;
            hist_waddr = hist_addr(head_reg, copy_wci_reg);
            hist_wdata = (copy_wci_reg == '0) ? sample_reg : hist_rdata;
            hist_raddr = hist_addr(prev_row_reg, copy_cnt_reg[CI_W-1:0]);
        end
        else
        begin
            hist_we    = acc_sample && (cp != '0);
            hist_waddr = hist_addr(head_reg, cp[CI_W-1:0]);
            hist_wdata = in_data.data_value;
            hist_raddr = hist_addr(row_reg, ci_reg);
        end
    end

    assign w_we    = acc_weight && w_in_range;
    assign w_waddr = wt_addr(int'(in_data.tap_index), int'(in_data.in_channel_index),
                             int'(in_data.out_channel_index));
    assign w_raddr = wt_addr(int'(kt_reg), int'(ci_reg), int'(co_reg));

    scv_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (HDEPTH)
    ) u_hist (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    scv_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WDEPTH)
    ) u_wgt (
        .clk   (clk),
        .we    (w_we),
        .waddr (w_waddr),
        .wdata (in_data.data_value),
        .raddr (w_raddr),
        .rdata (w_rdata)
    );

    scv_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (rd_ctl_reg),
        .sample (hist_rdata),
        .weight (w_rdata),
        .acc    (mac_acc),
        .done   (mac_done)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== rtl/scv_checker.sv =====
// Port-level checker for the convolution engine, bound to the top level.
module scv_port_checks (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input scv_pkg::in_item_t              in_data,
    input logic                           out_valid,
    input logic                           out_ready,
    input scv_pkg::out_item_t             out_data,
    input logic                           cfg_valid,
    input logic                           cfg_ready
);
    import scv_pkg::*;

    // held result must not change under backpressure
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // weight writes leave the block ready again in the next cycle
    a_weight_1cyc: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_data.cmd == CMD_WEIGHT) |=> in_ready)
        else $error("weight write did not return to idle");

    // mid-frame results: block is busy with the next output channel
    a_frame_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_data.last_of_frame |-> !in_ready)
        else $error("input taken in the middle of an output frame");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write refused");

endmodule

bind strided_conv1d_engine scv_port_checks u_scv_checker (.*);
